[rtl/srt_pkg.sv]
// srt_pkg: types, codes and constants shared by the sorted record table
// used by srt_cell and sorted_record_table; depends on nothing

package srt_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int INDEX_W       = 6;
    localparam int COUNT_W       = 7;
    localparam int KEY_W         = 64;
    localparam int CAP_W         = 32;
    localparam int KIND_W        = 8;
    localparam int IDENT_W       = 64;
    localparam int CHANGE_W      = 64;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } t_state;

    // field order gives the sort order: the packed vector compares as the composite key
    typedef struct packed {
        logic [CAP_W-1:0]   cap;
        logic [KIND_W-1:0]  kind;
        logic [IDENT_W-1:0] ident;
        logic [KEY_W-1:0]   key;
    } t_rec;

    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

[rtl/srt_cell.sv]
// srt_cell: one slot of the sorted chain, holds a record and its compare flags
// depends on srt_pkg

module srt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srt_pkg::t_cell_ctl i_ctl,
    input  srt_pkg::t_rec     i_new,
    input  logic              i_occupied,
    input  logic              i_index_hit,
    input  srt_pkg::t_rec     i_prev_entry,
    input  logic              i_prev_before,
    input  srt_pkg::t_rec     i_next_entry,
    input  logic              i_found_in,
    output srt_pkg::t_rec     o_entry,
    output logic              o_before,
    output logic              o_match,
    output logic              o_sel,
    output logic              o_found
);

    srt_pkg::t_rec r_entry;
    logic          r_before;
    logic          r_match;
    logic          r_sel;

    // compare flags, taken against the table as it stands at capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_before <= 1'b0;
            r_match  <= 1'b0;
            r_sel    <= 1'b0;
        end else if (i_ctl.capture) begin
            r_before <= i_occupied && (r_entry < i_new);
            r_match  <= i_occupied && (r_entry.key == i_new.key);
            r_sel    <= i_occupied && i_index_hit;
        end
    end

    // shift right on insert, left on remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && !r_before) begin
            r_entry <= i_prev_before ? i_new : i_prev_entry;
        end else if (i_ctl.remove && (i_found_in || r_match)) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry  = r_entry;
    assign o_before = r_before;
    assign o_match  = r_match;
    assign o_sel    = r_sel;
    assign o_found  = i_found_in || r_match;

endmodule

[rtl/sorted_record_table.sv]
// sorted_record_table: top level, chain of srt_cell slots plus control
// depends on srt_pkg and srt_cell

// Holds up to TABLE_DEPTH records in ascending order of (capability, subject
// kind, subject identifier, record key), one record per cell of a chain.
// For each transaction, at the accept edge every cell compares its record
// with the incoming one and registers its flags; then, in the commit state
// and once the output register is free, the whole chain shifts by one slot
// in a single step (insert or remove) and the result is written to the
// output register. A result waiting in the output register does not block the
// next accept; only the commit step waits until the output register is free.
// Stored records are not cleared at reset or by a clear action; the fill
// count alone decides which cells hold records, so there is no clearing pass.
// Read fields of a result are zero unless a read succeeds.

module sorted_record_table #(
    parameter int TABLE_DEPTH = srt_pkg::DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [srt_pkg::KEY_W-1:0]    i_record_key,
    input  logic [srt_pkg::CAP_W-1:0]    i_capability,
    input  logic [srt_pkg::KIND_W-1:0]   i_subject_kind,
    input  logic [srt_pkg::IDENT_W-1:0]  i_subject_ident,
    input  logic [srt_pkg::INDEX_W-1:0]  i_entry_index,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [srt_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [srt_pkg::CHANGE_W-1:0] o_change_count,
    output logic [srt_pkg::KEY_W-1:0]    o_read_key,
    output logic [srt_pkg::CAP_W-1:0]    o_read_capability,
    output logic [srt_pkg::KIND_W-1:0]   o_read_kind,
    output logic [srt_pkg::IDENT_W-1:0]  o_read_ident
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    // control state
    srt_pkg::t_state           r_state, n_state;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic [srt_pkg::CHANGE_W-1:0] r_chg, n_chg;
    logic                      r_out_valid;

    // captured transaction
    srt_pkg::t_action          r_act;
    srt_pkg::t_rec             r_new;
    logic                      r_invalid;

    // result register
    srt_pkg::t_status          r_status, n_status;
    srt_pkg::t_rec             r_rd, n_rd;

    // chain wiring
    srt_pkg::t_rec             w_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    w_before;
    logic [TABLE_DEPTH-1:0]    w_match;
    logic [TABLE_DEPTH-1:0]    w_sel;
    logic [TABLE_DEPTH:0]      w_found;
    srt_pkg::t_cell_ctl        w_ctl;
    srt_pkg::t_rec             w_in_rec;

    logic                      w_accept;
    logic                      w_commit;
    logic                      w_do_ins;
    logic                      w_do_rem;
    logic                      w_in_invalid;
    srt_pkg::t_rec             w_rd_bus;
    logic                      w_any_match;
    logic                      w_any_sel;
    logic                      w_full;

    // one transaction at a time; the output register parts the two sides
    assign o_in_stall = (r_state != srt_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_commit   = (r_state == srt_pkg::S_COMMIT) && (!r_out_valid || !i_out_stall);

    assign w_in_rec.cap   = i_capability;
    assign w_in_rec.kind  = i_subject_kind;
    assign w_in_rec.ident = i_subject_ident;
    assign w_in_rec.key   = i_record_key;

    // validation of the incoming transaction, done before capture
    always_comb begin
        case (srt_pkg::t_action'(i_action))
            srt_pkg::ACT_ADD:    w_in_invalid = (i_record_key == '0) || (i_capability == '0) ||
                                                ((i_subject_kind != '0) && (i_subject_ident == '0));
            srt_pkg::ACT_REMOVE: w_in_invalid = (i_record_key == '0);
            default:             w_in_invalid = 1'b0;
        endcase
    end

    // cells compare against the incoming record straight from the ports at accept
    assign w_ctl.capture = w_accept;
    assign w_ctl.insert  = w_do_ins;
    assign w_ctl.remove  = w_do_rem;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        srt_pkg::t_rec w_prev;
        srt_pkg::t_rec w_next;
        logic          w_prev_before;
        logic          w_occupied;
        logic          w_index_hit;

        if (g == 0) begin : g_first
            assign w_prev        = r_new;
            assign w_prev_before = 1'b1;
        end else begin : g_mid
            assign w_prev        = w_entry[g-1];
            assign w_prev_before = w_before[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        assign w_occupied  = (g < int'(r_fill));
        assign w_index_hit = (int'(i_entry_index) == g);

        // insert takes the new record from the captured copy, compare uses the ports
        srt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new         (w_accept ? w_in_rec : r_new),
            .i_occupied    (w_occupied),
            .i_index_hit   (w_index_hit),
            .i_prev_entry  (w_prev),
            .i_prev_before (w_prev_before),
            .i_next_entry  (w_next),
            .i_found_in    (w_found[g]),
            .o_entry       (w_entry[g]),
            .o_before      (w_before[g]),
            .o_match       (w_match[g]),
            .o_sel         (w_sel[g]),
            .o_found       (w_found[g+1])
        );
    end

    // read select: at most one cell flags itself, so an and-or bus does the pick
    always_comb begin
        w_rd_bus = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_rd_bus = w_rd_bus | (w_sel[k] ? w_entry[k] : '0);
        end
    end

    assign w_any_match = |w_match;
    assign w_any_sel   = |w_sel;
    assign w_full      = (int'(r_fill) >= TABLE_DEPTH);

    // commit decision for the captured transaction
    always_comb begin
        n_status = srt_pkg::STAT_OK;
        n_rd     = '0;
        n_fill   = r_fill;
        n_chg    = r_chg;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        case (r_act)
            srt_pkg::ACT_ADD: begin
                if (r_invalid) begin
                    n_status = srt_pkg::STAT_INVALID;
                end else if (w_any_match) begin
                    n_status = srt_pkg::STAT_DUPLICATE;
                end else if (w_full) begin
                    n_status = srt_pkg::STAT_FULL;
                end else begin
                    w_do_ins = w_commit;
                    n_fill   = FILL_W'(r_fill + 1'b1);
                    n_chg    = r_chg + 1'b1;
                end
            end
            srt_pkg::ACT_REMOVE: begin
                if (r_invalid) begin
                    n_status = srt_pkg::STAT_INVALID;
                end else if (!w_any_match) begin
                    n_status = srt_pkg::STAT_NOT_FOUND;
                end else begin
                    w_do_rem = w_commit;
                    n_fill   = FILL_W'(r_fill - 1'b1);
                    n_chg    = r_chg + 1'b1;
                end
            end
            srt_pkg::ACT_CLEAR: begin
                n_fill = '0;
                n_chg  = r_chg + 1'b1;
            end
            default: begin
                // read at index: cells past the fill level never flag themselves
                if (w_any_sel) begin
                    n_rd = w_rd_bus;
                end else begin
                    n_status = srt_pkg::STAT_NOT_FOUND;
                end
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE:   if (w_accept) n_state = srt_pkg::S_COMMIT;
            srt_pkg::S_COMMIT: if (w_commit) n_state = srt_pkg::S_IDLE;
            default:           n_state = srt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table count, change counter and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_chg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_fill      <= n_fill;
                r_chg       <= n_chg;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured transaction and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act     <= srt_pkg::t_action'(i_action);
            r_new     <= w_in_rec;
            r_invalid <= w_in_invalid;
        end
        if (w_commit) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
    end

    // entry count and change count reflect the table after the transaction
    logic [srt_pkg::COUNT_W-1:0]  r_out_count;
    logic [srt_pkg::CHANGE_W-1:0] r_out_chg;

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_count <= srt_pkg::COUNT_W'(n_fill);
            r_out_chg   <= n_chg;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_entry_count     = r_out_count;
    assign o_change_count    = r_out_chg;
    assign o_read_key        = r_rd.key;
    assign o_read_capability = r_rd.cap;
    assign o_read_kind       = r_rd.kind;
    assign o_read_ident      = r_rd.ident;

    // fill level never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= TABLE_DEPTH)
        else $error("fill level above table depth");

    // an index names at most one occupied cell
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one cell selected for read");

    // a successful add grows the table by exactly one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_act == srt_pkg::ACT_ADD) && (n_status == srt_pkg::STAT_OK))
        |=> (r_fill == FILL_W'($past(r_fill) + 1'b1)))
        else $error("add did not grow the table by one");

    // a failed transaction leaves the change counter alone
    a_fail_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (n_status != srt_pkg::STAT_OK)) |=> $stable(r_chg))
        else $error("change counter moved on a failed transaction");

endmodule

[sim/sorted_record_table_tb.sv]
// sorted_record_table_tb: self-checking bench for the sorted record table
// random and directed transactions with a shadow copy of the sorted table
// depends on srt_pkg and sorted_record_table

`timescale 1ns / 100ps

import srt_pkg::*;

// one result transaction as the table reports it
typedef struct packed {
    t_status                status;
    logic [COUNT_W-1:0]     count;
    logic [CHANGE_W-1:0]    changes;
    t_rec                   entry;      // read fields, zero unless a read hits
} t_table_response;

// shadow of the table contents plus the queue of responses still owed
class record_table_scoreboard;
    int                     depth;
    t_rec                   rows[$];    // kept in ascending composite-key order
    logic [CHANGE_W-1:0]    change_total;
    t_table_response        awaited_responses[$];
    int                     failures;

    function new(int table_depth);
        depth        = table_depth;
        change_total = '0;
        failures     = 0;
    endfunction

    // position of a record key, -1 when absent
    function int locate(logic [KEY_W-1:0] key);
        for (int i = 0; i < rows.size(); i++) begin
            if (rows[i].key == key) return i;
        end
        return -1;
    endfunction

    // apply one accepted request to the shadow and queue what it must answer
    function void note_request(t_action act, t_rec req, logic [INDEX_W-1:0] idx);
        t_table_response resp;
        int              pos;
        resp        = '0;
        resp.status = STAT_OK;
        case (act)
            ACT_ADD: begin
                // invalid wins over duplicate, duplicate over full
                if (req.key == '0 || req.cap == '0 || (req.kind != '0 && req.ident == '0)) begin
                    resp.status = STAT_INVALID;
                end else if (locate(req.key) >= 0) begin
                    resp.status = STAT_DUPLICATE;
                end else if (rows.size() >= depth) begin
                    resp.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < rows.size() &&
                           {rows[pos].cap, rows[pos].kind, rows[pos].ident, rows[pos].key} <
                           {req.cap, req.kind, req.ident, req.key}) begin
                        pos++;
                    end
                    rows.insert(pos, req);
                    change_total++;
                end
            end
            ACT_REMOVE: begin
                pos = locate(req.key);
                if (req.key == '0) begin
                    resp.status = STAT_INVALID;
                end else if (pos < 0) begin
                    resp.status = STAT_NOT_FOUND;
                end else begin
                    rows.delete(pos);
                    change_total++;
                end
            end
            ACT_CLEAR: begin
                // counts as a change even on an empty table
                rows.delete();
                change_total++;
            end
            default: begin
                if (idx < rows.size()) resp.entry = rows[idx];
                else resp.status = STAT_NOT_FOUND;
            end
        endcase
        resp.count   = COUNT_W'(rows.size());
        resp.changes = change_total;
        awaited_responses.push_back(resp);
    endfunction

    function void check_response(t_table_response got);
        t_table_response want;
        if (awaited_responses.size() == 0) begin
            failures++;
            if (failures <= 10) $display("result transaction with nothing awaited: %p", got);
        end else begin
            want = awaited_responses.pop_front();
            if (got.status !== want.status || got.count !== want.count ||
                got.changes !== want.changes || got.entry.key !== want.entry.key ||
                got.entry.cap !== want.entry.cap || got.entry.kind !== want.entry.kind ||
                got.entry.ident !== want.entry.ident) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch (expected / actual): status %0d / %0d, count %0d / %0d, changes %0d / %0d",
                             want.status, got.status, want.count, got.count,
                             want.changes, got.changes);
                    $display("  read key %h / %h, cap %h / %h, kind %h / %h, ident %h / %h",
                             want.entry.key, got.entry.key, want.entry.cap, got.entry.cap,
                             want.entry.kind, got.entry.kind, want.entry.ident, got.entry.ident);
                end
            end
        end
    endfunction
endclass

module sorted_record_table_tb;

    localparam int TABLE_DEPTH = 64;

    typedef enum int {HOLD_NONE, HOLD_HALF, HOLD_HEAVY, HOLD_PERIODIC} t_hold_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_action = ACT_READ;
    logic [KEY_W-1:0]     i_record_key = '0;
    logic [CAP_W-1:0]     i_capability = '0;
    logic [KIND_W-1:0]    i_subject_kind = '0;
    logic [IDENT_W-1:0]   i_subject_ident = '0;
    logic [INDEX_W-1:0]   i_entry_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [COUNT_W-1:0]   o_entry_count;
    logic [CHANGE_W-1:0]  o_change_count;
    logic [KEY_W-1:0]     o_read_key;
    logic [CAP_W-1:0]     o_read_capability;
    logic [KIND_W-1:0]    o_read_kind;
    logic [IDENT_W-1:0]   o_read_ident;

    record_table_scoreboard mirror;
    t_table_response        observed;
    t_rec                   offered;
    int                     burst_left = 0;
    int                     hold_left = 0;
    t_hold_mode             hold_mode = HOLD_NONE;

    sorted_record_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_record_key      (i_record_key),
        .i_capability      (i_capability),
        .i_subject_kind    (i_subject_kind),
        .i_subject_ident   (i_subject_ident),
        .i_entry_index     (i_entry_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_entry_count     (o_entry_count),
        .o_change_count    (o_change_count),
        .o_read_key        (o_read_key),
        .o_read_capability (o_read_capability),
        .o_read_kind       (o_read_kind),
        .o_read_ident      (o_read_ident)
    );

    always #4 i_clk = ~i_clk;

    // receiver back-pressure: each stretch picks its own stall pattern
    always @(negedge i_clk) begin
        if (hold_left == 0) begin
            hold_mode = t_hold_mode'($urandom_range(0, 3));
            hold_left = $urandom_range(16, 64);
        end else begin
            hold_left--;
        end
        case (hold_mode)
            HOLD_NONE:  i_out_stall = 1'b0;
            HOLD_HALF:  i_out_stall = ($urandom_range(0, 1) == 1);
            HOLD_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
            default:    i_out_stall = (hold_left % 3 == 0);
        endcase
    end

    // both channels sampled at the rising edge; results checked before the
    // request of the same edge is noted, so a stray result is never masked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                observed.status      = t_status'(o_status);
                observed.count       = o_entry_count;
                observed.changes     = o_change_count;
                observed.entry.key   = o_read_key;
                observed.entry.cap   = o_read_capability;
                observed.entry.kind  = o_read_kind;
                observed.entry.ident = o_read_ident;
                mirror.check_response(observed);
            end
            if (i_in_valid && !o_in_stall) begin
                offered = {i_capability, i_subject_kind, i_subject_ident, i_record_key};
                mirror.note_request(t_action'(i_action), offered, i_entry_index);
            end
        end
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // stored_pct biases toward keys already in the table (duplicates, remove hits)
    function automatic logic [KEY_W-1:0] pick_key(int stored_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < stored_pct && mirror.rows.size() > 0)
            return mirror.rows[$urandom_range(0, mirror.rows.size() - 1)].key;
        if (roll < stored_pct + 4) return '0;
        if (roll < stored_pct + 20) return KEY_W'($urandom_range(1, 8));
        return wide_random();
    endfunction

    // small pools make ties on the leading sort fields common
    function automatic logic [CAP_W-1:0] pick_cap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return '0;
        if (roll < 50) return CAP_W'($urandom_range(1, 3));
        if (roll < 60) return '1;
        return CAP_W'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return '0;
        if (roll < 70) return KIND_W'($urandom_range(1, 2));
        return KIND_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [IDENT_W-1:0] pick_ident();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 50) return IDENT_W'($urandom_range(1, 3));
        return wide_random();
    endfunction

    // mostly live positions, one past the end, or anywhere in range
    function automatic logic [INDEX_W-1:0] pick_index();
        int n;
        n = mirror.rows.size();
        if (n == 0 || $urandom_range(0, 9) < 3) return INDEX_W'($urandom_range(0, 63));
        return INDEX_W'($urandom_range(0, (n > 63) ? 63 : n));
    endfunction

    // called at a falling edge; returns at a falling edge with valid still
    // high inside a burst, so the next call drives its payload at once
    task automatic send_request(input t_action act, input logic [KEY_W-1:0] key,
                                input logic [CAP_W-1:0] cap, input logic [KIND_W-1:0] kind,
                                input logic [IDENT_W-1:0] ident,
                                input logic [INDEX_W-1:0] idx);
        i_action        = act;
        i_record_key    = key;
        i_capability    = cap;
        i_subject_kind  = kind;
        i_subject_ident = ident;
        i_entry_index   = idx;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // weights in percent; what is left over goes to reads
    task automatic run_phase(input int count, input int w_add, input int w_remove,
                             input int w_clear);
        t_action act;
        int      roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < w_add) act = ACT_ADD;
            else if (roll < w_add + w_remove) act = ACT_REMOVE;
            else if (roll < w_add + w_remove + w_clear) act = ACT_CLEAR;
            else act = ACT_READ;
            send_request(act, pick_key((act == ACT_REMOVE) ? 75 : 25), pick_cap(),
                         pick_kind(), pick_ident(), pick_index());
        end
    endtask

    // sender holds off until every awaited response has come back
    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (mirror.awaited_responses.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        mirror = new(TABLE_DEPTH);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, validation order, sort ties, extremes
        send_request(ACT_READ,   '0, '0, '0, '0, '0);
        send_request(ACT_REMOVE, 64'd5, 32'd1, '0, '0, '0);
        send_request(ACT_REMOVE, '0, 32'd1, '0, '0, '0);
        send_request(ACT_ADD,    '0, 32'd7, '0, '0, '0);
        send_request(ACT_ADD,    64'd11, '0, '0, '0, '0);
        send_request(ACT_ADD,    64'd12, 32'd7, 8'd3, '0, '0);      // kind set, no ident
        send_request(ACT_ADD,    64'd13, 32'd7, '0, '0, '0);        // no subject
        send_request(ACT_ADD,    '1, '1, '1, '1, '1);
        send_request(ACT_ADD,    64'd13, '0, '0, '0, '0);           // invalid beats duplicate
        send_request(ACT_ADD,    64'd13, 32'd9, 8'd1, 64'd2, '0);   // duplicate key
        send_request(ACT_ADD,    64'd20, 32'd7, 8'd2, 64'd5, '0);
        send_request(ACT_ADD,    64'd21, 32'd7, 8'd2, 64'd4, '0);   // ident decides
        send_request(ACT_ADD,    64'd19, 32'd7, 8'd2, 64'd4, '0);   // only the key decides
        send_request(ACT_ADD,    64'd22, 32'd7, 8'd1, 64'd99, '0);  // kind decides
        send_request(ACT_ADD,    64'd1, 32'd1, 8'd200, 64'd1, '0);
        send_request(ACT_READ,   '0, '0, '0, '0, 6'd0);
        send_request(ACT_READ,   '0, '0, '0, '0, 6'd3);
        send_request(ACT_READ,   '0, '0, '0, '0, 6'd6);
        send_request(ACT_READ,   '0, '0, '0, '0, '1);              // past the fill level
        send_request(ACT_REMOVE, 64'd20, '0, '0, '0, '0);
        send_request(ACT_READ,   '0, '0, '0, '0, 6'd2);
        send_request(ACT_CLEAR,  '0, '0, '0, '0, '0);
        send_request(ACT_CLEAR,  '0, '0, '0, '0, '0);              // clear when already empty
        wait_results_drained();

        // fill to the top and push against full, then drain, then mix
        repeat (2) begin
            run_phase(160, 85, 3, 0);
            wait_results_drained();
            run_phase(110, 15, 60, 0);
            run_phase(110, 40, 30, 5);
            wait_results_drained();
        end

        repeat (8) @(negedge i_clk);
        if (mirror.failures == 0 && mirror.awaited_responses.size() == 0) begin
            $display("[sorted_record_table] OK");
        end else begin
            $display("[sorted_record_table] ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[sorted_record_table] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/sorted_record_table.sv
sim/sorted_record_table_tb.sv
